/* design/days_between_dates_macros.svh */
// Assertion macros used by dbd_ctrl.
`ifndef DAYS_BETWEEN_DATES_MACROS_SVH
`define DAYS_BETWEEN_DATES_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dbd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dbd: next-cycle check failed");

`endif

/* design/dbd_pkg.sv */
`default_nettype none

package dbd_pkg;

  // Field widths.
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned CNT_W   = 22;

  // Day ordinal width: below 4095 * 366 + 400.
  localparam int unsigned ORD_W = 21;

  // Year quotients by 100 stay below 41.
  localparam int unsigned QUO_W = 6;

  // Constant multiplier width and product width.
  localparam int unsigned K_W    = 13;
  localparam int unsigned PROD_W = YEAR_W + K_W;

  localparam logic [YEAR_W-1:0] MAX_YEAR = 12'd4095;

  // floor(x / 100) = (x * 5243) >> 19, exact for all 12-bit x.
  localparam logic [K_W-1:0] RECIP_100   = 13'd5243;
  localparam int unsigned    RECIP_SHIFT = 19;
  localparam logic [K_W-1:0] DAYS_YEAR   = 13'd365;
  localparam logic [K_W-1:0] HUNDRED     = 13'd100;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_QP,
    OP_QY,
    OP_YRS,
    OP_REM,
    OP_ACC1,
    OP_ACC2,
    OP_DIFF
  } op_e;

  // Which of the two dates the datapath works on.
  typedef enum logic {
    SIDE_START,
    SIDE_END
  } side_e;

  typedef struct packed {
    op_e   op;
    side_e side;
  } cmd_t;

  typedef struct packed {
    logic bad;
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QP,
    ST_QY,
    ST_YRS,
    ST_REM,
    ST_ACC1,
    ST_ACC2,
    ST_DIFF
  } state_e;

  // Days in the whole months before month m of a common year.
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/dbd_ctrl.sv */
`default_nettype none
`include "days_between_dates_macros.svh"

module dbd_ctrl
  import dbd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  status_t      status_i,
  output cmd_t         cmd_o,
  output logic         busy_o,
  output logic         done_o
);

  state_e state_q, state_d;
  side_e  side_q, side_d;
  logic   done_q, done_d;

  // State, side and done strobe registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      side_q  <= SIDE_START;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
      done_q  <= done_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    side_d      = side_q;
    done_d      = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.side  = side_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          side_d   = SIDE_START;
          state_d  = ST_QP;
        end
      end
      ST_QP: begin
        // An invalid date skips the arithmetic entirely.
        if (status_i.bad) begin
          state_d = ST_DIFF;
        end else begin
          cmd_o.op = OP_QP;
          state_d  = ST_QY;
        end
      end
      ST_QY: begin
        cmd_o.op = OP_QY;
        state_d  = ST_YRS;
      end
      ST_YRS: begin
        cmd_o.op = OP_YRS;
        state_d  = ST_REM;
      end
      ST_REM: begin
        cmd_o.op = OP_REM;
        state_d  = ST_ACC1;
      end
      ST_ACC1: begin
        cmd_o.op = OP_ACC1;
        state_d  = ST_ACC2;
      end
      ST_ACC2: begin
        cmd_o.op = OP_ACC2;
        if (side_q == SIDE_START) begin
          side_d  = SIDE_END;
          state_d = ST_QP;
        end else begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.op = OP_DIFF;
        done_d   = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

  // The strobe lasts one cycle, follows the final step, and an accepted
  // transfer always makes the block busy.
  `DBD_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q)
  `DBD_ASSERT_NEXT(a_done_after_diff, clk_i, rst_ni, state_q == ST_DIFF, done_q)
  `DBD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `DBD_ASSERT_SAME(a_done_idle, clk_i, rst_ni, done_q, state_q == ST_IDLE)

endmodule

`default_nettype wire

/* design/dbd_dpath.sv */
`default_nettype none

module dbd_dpath
  import dbd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic [DAY_W-1:0]    start_day_i,
  input  wire logic [MONTH_W-1:0]  start_month_i,
  input  wire logic [YEAR_W-1:0]   start_year_i,
  input  wire logic [DAY_W-1:0]    end_day_i,
  input  wire logic [MONTH_W-1:0]  end_month_i,
  input  wire logic [YEAR_W-1:0]   end_year_i,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  output logic signed [CNT_W-1:0]  day_count_o,
  output logic                     bad_date_o
);

  logic [DAY_W-1:0]   sd_q, ed_q;
  logic [MONTH_W-1:0] sm_q, em_q;
  logic [YEAR_W-1:0]  sy_q, ey_q;
  logic               bad_q;
  logic [QUO_W-1:0]   qp_q, qy_q;
  logic [ORD_W-1:0]   yrs_q, acc_q, ords_q, orde_q;
  logic               leap_q;
  logic signed [CNT_W-1:0] cnt_q;
  logic               bdo_q;

  logic [DAY_W-1:0]   cur_d;
  logic [MONTH_W-1:0] cur_m;
  logic [YEAR_W-1:0]  cur_y, cur_p;
  logic [YEAR_W-1:0]  mult_a;
  logic [K_W-1:0]     mult_k;
  logic [PROD_W-1:0]  prod;
  logic [ORD_W-1:0]   ord_v;
  logic               bad_v;

  // Date under work.
  always_comb begin
    if (cmd_i.side == SIDE_END) begin
      cur_d = ed_q;
      cur_m = em_q;
      cur_y = ey_q;
    end else begin
      cur_d = sd_q;
      cur_m = sm_q;
      cur_y = sy_q;
    end
    cur_p = cur_y - 12'd1;
  end

  // Range check on the incoming transfer.
  always_comb begin
    bad_v = (start_month_i == '0) || (start_month_i > 4'd12) ||
            (end_month_i == '0) || (end_month_i > 4'd12) ||
            (start_year_i == '0) || (start_year_i > MAX_YEAR) ||
            (end_year_i == '0) || (end_year_i > MAX_YEAR);
  end

  // Shared constant multiplier.
  always_comb begin
    case (cmd_i.op)
      OP_QP: begin
        mult_a = cur_p;
        mult_k = RECIP_100;
      end
      OP_QY: begin
        mult_a = cur_y;
        mult_k = RECIP_100;
      end
      OP_YRS: begin
        mult_a = cur_p;
        mult_k = DAYS_YEAR;
      end
      OP_REM: begin
        mult_a = YEAR_W'(qy_q);
        mult_k = HUNDRED;
      end
      default: begin
        mult_a = '0;
        mult_k = '0;
      end
    endcase
    prod = PROD_W'(mult_a) * PROD_W'(mult_k);
  end

  // Second half of the ordinal: months, leap day and day of month.
  assign ord_v = acc_q + ORD_W'(days_before_month(cur_m)) +
                 ORD_W'(leap_q && (cur_m > 4'd2)) + ORD_W'(cur_d);

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        sd_q  <= start_day_i;
        sm_q  <= start_month_i;
        sy_q  <= start_year_i;
        ed_q  <= end_day_i;
        em_q  <= end_month_i;
        ey_q  <= end_year_i;
        bad_q <= bad_v;
      end
      OP_QP: begin
        qp_q <= prod[RECIP_SHIFT +: QUO_W];
      end
      OP_QY: begin
        qy_q <= prod[RECIP_SHIFT +: QUO_W];
      end
      OP_YRS: begin
        yrs_q <= prod[ORD_W-1:0];
      end
      OP_REM: begin
        // Leap when divisible by 4, and by 400 if divisible by 100.
        leap_q <= (cur_y[1:0] == 2'b00) &&
                  ((cur_y != prod[YEAR_W-1:0]) || (qy_q[1:0] == 2'b00));
      end
      OP_ACC1: begin
        acc_q <= yrs_q + ORD_W'(cur_p[YEAR_W-1:2]) - ORD_W'(qp_q) +
                 ORD_W'(qp_q[QUO_W-1:2]);
      end
      OP_ACC2: begin
        if (cmd_i.side == SIDE_END) begin
          orde_q <= ord_v;
        end else begin
          ords_q <= ord_v;
        end
      end
      OP_DIFF: begin
        bdo_q <= bad_q;
        if (bad_q) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= $signed(CNT_W'(orde_q) - CNT_W'(ords_q));
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o.bad = bad_q;
  assign day_count_o  = cnt_q;
  assign bad_date_o   = bdo_q;

endmodule

`default_nettype wire

/* design/days_between_dates.sv */
// Gregorian day difference between a start date and an end date.
// Command channel: drive the six date fields and raise start_i; the
// transfer happens at the rising edge where start_i is high and busy_o low.
// Result channel: done_o is high for exactly one cycle while day_count_o
// (signed, end minus start) and bad_date_o hold the result; the receiver
// cannot stall, so the result must be taken in that cycle. The ports keep
// their value afterwards until the next result.
// Valid dates pass through every step below before done_o; when a month
// or year is out of range, the date steps are skipped (day_count_o is 0).
// Each date takes six steps: four through one shared constant multiplier
// (two quotients by 100, the year days, the leap test) and two adder steps.
// One more step then forms the difference. busy_o falls in the done_o
// cycle, so a new command can be taken at the edge that ends it; no new
// command is taken while one is in flight.
// Reset (rst_ni low, asynchronous) returns the controller to idle and
// clears done_o; any item in flight is dropped.
`default_nettype none

module days_between_dates
  import dbd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [DAY_W-1:0]    start_day_i,
  input  wire logic [MONTH_W-1:0]  start_month_i,
  input  wire logic [YEAR_W-1:0]   start_year_i,
  input  wire logic [DAY_W-1:0]    end_day_i,
  input  wire logic [MONTH_W-1:0]  end_month_i,
  input  wire logic [YEAR_W-1:0]   end_year_i,
  output logic                     done_o,
  output logic signed [CNT_W-1:0]  day_count_o,
  output logic                     bad_date_o
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  dbd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  // Arithmetic and result registers.
  dbd_dpath u_dpath (
    .clk_i         (clk_i),
    .start_day_i   (start_day_i),
    .start_month_i (start_month_i),
    .start_year_i  (start_year_i),
    .end_day_i     (end_day_i),
    .end_month_i   (end_month_i),
    .end_year_i    (end_year_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .day_count_o   (day_count_o),
    .bad_date_o    (bad_date_o)
  );

endmodule

`default_nettype wire
